/* rtl/cts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and codes for the cooperative task scheduler.
// ----------------------------------------------------------------------------
package cts_pkg;

  typedef enum logic [2:0] {
    ACT_SPAWN    = 3'd0,
    ACT_DISPATCH = 3'd1,
    ACT_YIELD    = 3'd2,
    ACT_PARK     = 3'd3,
    ACT_SLEEP    = 3'd4,
    ACT_EXIT     = 3'd5,
    ACT_UNPARK   = 3'd6,
    ACT_RSTAT    = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    SL_FREE     = 3'd0,
    SL_READY    = 3'd1,
    SL_RUNNING  = 3'd2,
    SL_PARKED   = 3'd3,
    SL_SLEEPING = 3'd4,
    SL_DONE     = 3'd5
  } slot_st_t;

  typedef enum logic [1:0] {
    CODE_OK     = 2'd0,
    CODE_IGNORE = 2'd1,
    CODE_NOFREE = 2'd2,
    CODE_DROP   = 2'd3
  } code_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_WAKE,
    ST_PREP,
    ST_APPLY,
    ST_QUERY,
    ST_RESULT
  } ctrl_st_t;

  typedef struct packed {
    act_t               action;
    logic [7:0]         target_slot;
    logic signed [31:0] sleep_ms;
    logic [31:0]        now_ms;
  } sched_in_t;

  typedef struct packed {
    code_t       code;
    logic        run_valid;
    logic [7:0]  chosen_slot;
    logic        sleepers_present;
    logic [31:0] soonest_wake;
    logic        all_idle;
    slot_st_t    queried_state;
    logic [8:0]  active_tasks;
    logic [31:0] pop_count;
  } sched_out_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic scan_en;
    logic find_mode;
    logic apply;
    logic load;
  } cts_cmd_t;

  typedef struct packed {
    logic clear_done;
    act_t new_action;
    logic cur_valid;
    logic scan_done;
    logic found;
    logic out_free;
  } cts_stat_t;

endpackage

/* rtl/cts_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_ctrl
// Sequencer: clearing pass, slot scans, event apply, query and result load.
// ----------------------------------------------------------------------------
module cts_ctrl import cts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cts_stat_t stat,
  output cts_cmd_t  cmd
);

  ctrl_st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (stat.new_action)
            ACT_SPAWN:    state_nxt = ST_FIND;
            ACT_DISPATCH: state_nxt = stat.cur_valid ? ST_PREP : ST_WAKE;
            default:      state_nxt = ST_PREP;
          endcase
        end
      end
      ST_FIND: begin
        if (stat.found || stat.scan_done) state_nxt = ST_APPLY;
      end
      ST_WAKE: begin
        if (stat.scan_done) state_nxt = ST_PREP;
      end
      ST_PREP:  state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_QUERY;
      ST_QUERY: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.clear     = (state_r == ST_CLEAR);
    cmd.accept    = (state_r == ST_IDLE) && in_valid;
    cmd.scan_en   = (state_r == ST_FIND) || (state_r == ST_WAKE);
    cmd.find_mode = (state_r == ST_FIND);
    cmd.apply     = (state_r == ST_APPLY);
    cmd.load      = (state_r == ST_RESULT) && stat.out_free;
    in_stall      = (state_r != ST_IDLE);
  end

endmodule

/* rtl/cts_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_datapath
// Slot table, wake times, ready ring, counters and the output register.
// ----------------------------------------------------------------------------
module cts_datapath import cts_pkg::*; #(
  parameter int SLOTS     = 256,
  parameter int TIME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  sched_in_t  in_data,
  input  cts_cmd_t   cmd,
  output cts_stat_t  stat,
  output logic       out_valid,
  input  logic       out_stall,
  output sched_out_t out_data
);

  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int SUMW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

  slot_st_t             st_mem   [SLOTS];
  logic [TIME_BITS-1:0] wk_mem   [SLOTS];
  logic [SW-1:0]        ring_mem [SLOTS];

  slot_st_t             st_q;
  logic [TIME_BITS-1:0] wk_q;
  logic [SW-1:0]        ring_q;

  sched_in_t            item_r, item_nxt;
  logic [SW-1:0]        head_r, head_nxt, tail_r, tail_nxt;
  logic                 cur_valid_r, cur_valid_nxt;
  logic [SW-1:0]        cur_slot_r, cur_slot_nxt;
  logic [CW-1:0]        active_r, active_nxt;
  logic [31:0]          pops_r, pops_nxt;
  logic                 sleepers_r, sleepers_nxt;
  logic [TIME_BITS-1:0] min_r, min_nxt;
  code_t                code_r, code_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic [SW-1:0]        chosen_r, chosen_nxt;
  logic                 found_r, found_nxt;
  logic [SW-1:0]        found_idx_r, found_idx_nxt;
  logic [SW:0]          scan_idx_r, scan_idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [SW-1:0]        pend_idx_r, pend_idx_nxt;
  logic [SW-1:0]        clr_idx_r, clr_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sched_out_t           out_r, out_nxt;

  logic                 tgt_ok;
  logic [SW-1:0]        tgt_idx;
  logic [TIME_BITS-1:0] now_t;
  logic                 ms_pos;
  logic [SUMW-1:0]      sum_w;
  logic [TIME_BITS-1:0] wake_t;
  logic [SW-1:0]        head_inc, tail_inc;
  logic                 ring_full, ring_empty;
  logic                 issue, proc_en;
  logic [SW-1:0]        rd_addr;

  logic                 st_we, wk_we, push, ring_we;
  logic [SW-1:0]        st_wa, wk_wa, push_val;
  slot_st_t             st_wd;
  logic [TIME_BITS-1:0] wk_wd;

  assign tgt_ok  = int'(item_r.target_slot) < SLOTS;
  assign tgt_idx = SW'(item_r.target_slot);
  assign now_t   = TIME_BITS'(item_r.now_ms);
  assign ms_pos  = (item_r.sleep_ms > 0);
  assign sum_w   = SUMW'(now_t) + SUMW'(item_r.sleep_ms[30:0]);
  // saturate when the sum spills past the time width
  assign wake_t  = (|(sum_w >> TIME_BITS)) ? '1 : sum_w[TIME_BITS-1:0];

  assign head_inc   = (head_r == SW'(SLOTS - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc   = (tail_r == SW'(SLOTS - 1)) ? '0 : tail_r + 1'b1;
  assign ring_full  = (tail_inc == head_r);
  assign ring_empty = (head_r == tail_r);

  // one read issued per cycle, its data is processed the cycle after
  assign issue   = cmd.scan_en && (scan_idx_r != (SW + 1)'(SLOTS))
                   && !(cmd.find_mode && found_r);
  assign proc_en = cmd.scan_en && pend_r;
  assign rd_addr = issue ? scan_idx_r[SW-1:0] : tgt_idx;

  always_comb begin
    item_nxt      = item_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cur_valid_nxt = cur_valid_r;
    cur_slot_nxt  = cur_slot_r;
    active_nxt    = active_r;
    pops_nxt      = pops_r;
    sleepers_nxt  = sleepers_r;
    min_nxt       = min_r;
    code_nxt      = code_r;
    run_valid_nxt = run_valid_r;
    chosen_nxt    = chosen_r;
    found_nxt     = found_r;
    found_idx_nxt = found_idx_r;
    scan_idx_nxt  = scan_idx_r;
    pend_nxt      = issue;
    pend_idx_nxt  = scan_idx_r[SW-1:0];
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    st_we         = 1'b0;
    st_wa         = pend_idx_r;
    st_wd         = SL_FREE;
    wk_we         = 1'b0;
    wk_wa         = pend_idx_r;
    wk_wd         = '0;
    push          = 1'b0;
    push_val      = pend_idx_r;

    if (cmd.clear) begin
      st_we       = 1'b1;
      st_wa       = clr_idx_r;
      wk_we       = 1'b1;
      wk_wa       = clr_idx_r;
      clr_idx_nxt = clr_idx_r + 1'b1;
    end

    if (cmd.accept) begin
      item_nxt      = in_data;
      scan_idx_nxt  = '0;
      found_nxt     = 1'b0;
      code_nxt      = CODE_OK;
      run_valid_nxt = 1'b0;
      chosen_nxt    = '0;
      // dispatch rebuilds the sleeper summary during its wake scan
      if ((in_data.action == ACT_DISPATCH) && !cur_valid_r) begin
        sleepers_nxt = 1'b0;
        min_nxt      = '0;
      end
    end

    if (issue) scan_idx_nxt = scan_idx_r + 1'b1;

    if (proc_en && cmd.find_mode) begin
      if (!found_r && ((st_q == SL_FREE) || (st_q == SL_DONE))) begin
        found_nxt     = 1'b1;
        found_idx_nxt = pend_idx_r;
      end
    end

    if (proc_en && !cmd.find_mode && (st_q == SL_SLEEPING)) begin
      if (wk_q <= now_t) begin
        st_we    = 1'b1;
        st_wd    = SL_READY;
        push     = 1'b1;
        push_val = pend_idx_r;
      end else begin
        sleepers_nxt = 1'b1;
        if (!sleepers_r || (wk_q < min_r)) min_nxt = wk_q;
      end
    end

    if (cmd.apply) begin
      case (item_r.action)
        ACT_SPAWN: begin
          if (!found_r) begin
            code_nxt = CODE_NOFREE;
          end else begin
            st_we      = 1'b1;
            st_wa      = found_idx_r;
            st_wd      = SL_READY;
            wk_we      = 1'b1;
            wk_wa      = found_idx_r;
            active_nxt = active_r + 1'b1;
            chosen_nxt = found_idx_r;
            push       = 1'b1;
            push_val   = found_idx_r;
          end
        end
        ACT_DISPATCH: begin
          if (cur_valid_r) begin
            code_nxt = CODE_IGNORE;
          end else if (!ring_empty) begin
            head_nxt      = head_inc;
            pops_nxt      = pops_r + 1'b1;
            st_we         = 1'b1;
            st_wa         = ring_q;
            st_wd         = SL_RUNNING;
            cur_valid_nxt = 1'b1;
            cur_slot_nxt  = ring_q;
            run_valid_nxt = 1'b1;
            chosen_nxt    = ring_q;
          end
        end
        ACT_YIELD, ACT_PARK, ACT_EXIT: begin
          if (!cur_valid_r) begin
            code_nxt = CODE_IGNORE;
          end else begin
            cur_valid_nxt = 1'b0;
            st_we         = 1'b1;
            st_wa         = cur_slot_r;
            if (item_r.action == ACT_YIELD) begin
              st_wd    = SL_READY;
              push     = 1'b1;
              push_val = cur_slot_r;
            end else if (item_r.action == ACT_PARK) begin
              st_wd = SL_PARKED;
            end else begin
              st_wd = SL_DONE;
              if (active_r != '0) active_nxt = active_r - 1'b1;
            end
          end
        end
        ACT_SLEEP: begin
          if (!cur_valid_r || !ms_pos) begin
            code_nxt = CODE_IGNORE;
          end else begin
            wk_we         = 1'b1;
            wk_wa         = cur_slot_r;
            wk_wd         = wake_t;
            st_we         = 1'b1;
            st_wa         = cur_slot_r;
            st_wd         = SL_SLEEPING;
            cur_valid_nxt = 1'b0;
            sleepers_nxt  = 1'b1;
            if (!sleepers_r || (wake_t < min_r)) min_nxt = wake_t;
          end
        end
        ACT_UNPARK: begin
          // st_q holds the target's state, read in the prep cycle
          if (!tgt_ok || (st_q != SL_PARKED)) begin
            code_nxt = CODE_IGNORE;
          end else begin
            st_we    = 1'b1;
            st_wa    = tgt_idx;
            st_wd    = SL_READY;
            push     = 1'b1;
            push_val = tgt_idx;
          end
        end
        ACT_RSTAT: pops_nxt = '0;
        default: ;
      endcase
    end

    ring_we = push && !ring_full;
    if (push) begin
      if (ring_full) code_nxt = CODE_DROP;
      else           tail_nxt = tail_inc;
    end

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load) begin
      out_valid_nxt            = 1'b1;
      out_nxt.code             = code_r;
      out_nxt.run_valid        = run_valid_r;
      out_nxt.chosen_slot      = 8'(chosen_r);
      out_nxt.sleepers_present = sleepers_r;
      out_nxt.soonest_wake     = 32'(min_r);
      out_nxt.all_idle         = (active_r == '0) && ring_empty && !sleepers_r;
      out_nxt.queried_state    = tgt_ok ? st_q : SL_FREE;
      out_nxt.active_tasks     = 9'(active_r);
      out_nxt.pop_count        = pops_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    st_q <= st_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wk_we) wk_mem[wk_wa] <= wk_wd;
    wk_q <= wk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[tail_r] <= push_val;
    ring_q <= ring_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cur_valid_r <= 1'b0;
      cur_slot_r  <= '0;
      active_r    <= '0;
      pops_r      <= '0;
      sleepers_r  <= 1'b0;
      min_r       <= '0;
      found_r     <= 1'b0;
      scan_idx_r  <= '0;
      pend_r      <= 1'b0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cur_valid_r <= cur_valid_nxt;
      cur_slot_r  <= cur_slot_nxt;
      active_r    <= active_nxt;
      pops_r      <= pops_nxt;
      sleepers_r  <= sleepers_nxt;
      min_r       <= min_nxt;
      found_r     <= found_nxt;
      scan_idx_r  <= scan_idx_nxt;
      pend_r      <= pend_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    code_r      <= code_nxt;
    run_valid_r <= run_valid_nxt;
    chosen_r    <= chosen_nxt;
    found_idx_r <= found_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    stat            = '0;
    stat.clear_done = (clr_idx_r == SW'(SLOTS - 1));
    stat.new_action = in_data.action;
    stat.cur_valid  = cur_valid_r;
    stat.scan_done  = (scan_idx_r == (SW + 1)'(SLOTS)) && !pend_r;
    stat.found      = found_r;
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/cooperative_task_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooperative_task_scheduler_top
// Task-slot scheduler with a slot state table and a FIFO ready ring.
// ----------------------------------------------------------------------------
// One event beat in, one result beat out. After reset the block runs a
// clearing pass over the slot table and takes no event until it ends.
// Events are handled one at a time. Spawn walks the slot table for the
// first free or done slot, one slot a cycle; dispatch (with no task
// running) walks all slots to wake due sleepers and rebuild the earliest
// wake time. Every other event goes through the prep, apply, query and
// result states. The single read port of the slot table sets the pace of
// both walks. A finished result sits in an output register, so the next
// event is taken while it waits to be drained.
module cooperative_task_scheduler_top import cts_pkg::*; #(
  parameter int SLOTS     = 256,
  parameter int TIME_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sched_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output sched_out_t out_data
);

  cts_cmd_t  cmd;
  cts_stat_t stat;

  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cts_datapath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
